// ===== hw/rtl/npcl1_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// npcl1_pkg: shared types and constants of the nearest palette color search
// Palette depth, cell count, the beat that travels down the cell row,
// configuration register codes and the absolute difference helper.
// ----------------------------------------------------------------------------
package npcl1_pkg;

  localparam int PALETTE_DEPTH = 256;
  localparam int ADDRESSABLE   = 256;
  localparam int NUM_CELLS     = (PALETTE_DEPTH < ADDRESSABLE) ? PALETTE_DEPTH : ADDRESSABLE;
  localparam int LATENCY       = NUM_CELLS + 1;

  localparam logic [7:0] START_BEST = 8'd255;

  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  typedef enum logic [1:0] {
    REG_COLOR_COUNT = 2'd0,
    REG_BLACK_INDEX = 2'd1,
    REG_WHITE_INDEX = 2'd2,
    REG_AVOID_BLACK = 2'd3
  } reg_idx_e;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } opcode_e;

  typedef struct packed {
    logic [8:0] color_count;
    logic [7:0] black_index;
    logic [7:0] white_index;
    logic       avoid_black;
  } cfg_t;

  // beat handed from cell to cell
  typedef struct packed {
    logic       query;
    logic [7:0] entry_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] best;
    logic [7:0] match;
    logic       hit;
  } beat_t;

  function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] r;
    r = (a > b) ? (a - b) : (b - a);
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/npcl1_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// npcl1_cfg: configuration registers
// APB-style register file holding color count, fallback indexes and the
// avoid-black select.
// ----------------------------------------------------------------------------
module npcl1_cfg
  import npcl1_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e reg_sel;
  logic     wr_en;

  assign reg_sel = reg_idx_e'(paddr[3:2]);
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_sel)
        REG_COLOR_COUNT: cfg_d.color_count = pwdata[8:0];
        REG_BLACK_INDEX: cfg_d.black_index = pwdata[7:0];
        REG_WHITE_INDEX: cfg_d.white_index = pwdata[7:0];
        REG_AVOID_BLACK: cfg_d.avoid_black = pwdata[0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (reg_sel)
      REG_COLOR_COUNT: prdata = {{(APB_DW-9){1'b0}}, cfg_q.color_count};
      REG_BLACK_INDEX: prdata = {{(APB_DW-8){1'b0}}, cfg_q.black_index};
      REG_WHITE_INDEX: prdata = {{(APB_DW-8){1'b0}}, cfg_q.white_index};
      REG_AVOID_BLACK: prdata = {{(APB_DW-1){1'b0}}, cfg_q.avoid_black};
      default:         prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

// ===== hw/rtl/npcl1_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// npcl1_cell: one palette entry cell
// Holds one RGB entry, loads it when a write beat for its slot passes, and
// folds its L1 distance into the running best of each passing query beat when
// its slot lies below the color count.
module npcl1_cell
  import npcl1_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic [7:0] cell_idx_i,
  input  wire logic [8:0] color_count_i,
  input  wire logic       valid_i,
  input  beat_t           beat_i,
  output logic            valid_o,
  output beat_t           beat_o
);

  logic [7:0] ent_red_q, ent_green_q, ent_blue_q;
  logic       valid_q;
  beat_t      beat_q, beat_d;
  logic [9:0] l1_sum;
  logic       searched;
  logic       win;
  logic       load;

  assign l1_sum = {2'b00, abs_diff(ent_red_q, beat_i.red)}
                + {2'b00, abs_diff(ent_green_q, beat_i.green)}
                + {2'b00, abs_diff(ent_blue_q, beat_i.blue)};

  assign searched = beat_i.query && ({1'b0, cell_idx_i} < color_count_i);
  assign win      = searched && (l1_sum < {2'b00, beat_i.best});
  assign load     = valid_i && !beat_i.query && (beat_i.entry_index == cell_idx_i);

  always_comb begin
    beat_d = beat_i;
    if (win) begin
      beat_d.best  = l1_sum[7:0];
      beat_d.match = cell_idx_i;
      beat_d.hit   = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    beat_q <= beat_d;
    if (load) begin
      ent_red_q   <= beat_i.red;
      ent_green_q <= beat_i.green;
      ent_blue_q  <= beat_i.blue;
    end
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule
`default_nettype wire

// ===== hw/rtl/nearest_palette_color_l1.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_palette_color_l1: nearest palette entry by L1 distance
// A query result passes the input register and then the register of each
// entry cell in turn. Throughput: one item per cycle, busy stays low; writes
// ride the same cell row, so each beat sees exactly the writes accepted
// before it. Reset clears the valid flags and configuration registers,
// dropping all beats in flight; palette contents are undefined until
// written. The result strobe cannot be stalled.
// ----------------------------------------------------------------------------
module nearest_palette_color_l1
  import npcl1_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic              opcode_i,
  input  wire logic [7:0]        entry_index_i,
  input  wire logic [7:0]        red_i,
  input  wire logic [7:0]        green_i,
  input  wire logic [7:0]        blue_i,
  output logic                   result_valid_o,
  output logic      [7:0]        match_index_o,
  output logic                   hit_o,
  output logic      [7:0]        best_distance_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready
);

  cfg_t  cfg;
  logic  in_valid_q;
  beat_t in_beat_q, in_beat_d;
  logic  chain_valid [NUM_CELLS+1];
  beat_t chain_beat  [NUM_CELLS+1];

  npcl1_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign busy = 1'b0;

  always_comb begin
    in_beat_d.query       = (opcode_e'(opcode_i) == OP_QUERY);
    in_beat_d.entry_index = entry_index_i;
    in_beat_d.red         = red_i;
    in_beat_d.green       = green_i;
    in_beat_d.blue        = blue_i;
    in_beat_d.best        = START_BEST;
    in_beat_d.match       = cfg.avoid_black ? cfg.white_index : cfg.black_index;
    in_beat_d.hit         = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= start & ~busy;
    end
  end

  always_ff @(posedge clk_i) begin
    in_beat_q <= in_beat_d;
  end

  assign chain_valid[0] = in_valid_q;
  assign chain_beat[0]  = in_beat_q;

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    npcl1_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .cell_idx_i    (8'(i)),
      .color_count_i (cfg.color_count),
      .valid_i       (chain_valid[i]),
      .beat_i        (chain_beat[i]),
      .valid_o       (chain_valid[i+1]),
      .beat_o        (chain_beat[i+1])
    );
  end

  assign result_valid_o  = chain_valid[NUM_CELLS] & chain_beat[NUM_CELLS].query;
  assign match_index_o   = chain_beat[NUM_CELLS].match;
  assign hit_o           = chain_beat[NUM_CELLS].hit;
  assign best_distance_o = chain_beat[NUM_CELLS].best;

endmodule
`default_nettype wire

// ===== hw/rtl/npcl1_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// npcl1_checker: port-level checks of the nearest palette color search
// Watches the top-level ports for result timing, result consistency and pready.
// ----------------------------------------------------------------------------
module npcl1_checker
  import npcl1_pkg::*;
(
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       opcode_i,
  input wire logic       result_valid_o,
  input wire logic       hit_o,
  input wire logic [7:0] best_distance_o,
  input wire logic       pready
);

  // every result beat comes from an earlier accepted query
  a_result_from_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> ($past(start & ~busy, LATENCY) && $past(opcode_i, LATENCY)))
    else $error("result beat without matching query");

  a_fallback_distance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !hit_o) |-> (best_distance_o == START_BEST))
    else $error("fallback result with distance other than 255");

  a_hit_distance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && hit_o) |-> (best_distance_o != START_BEST))
    else $error("hit result with distance 255");

  a_pready_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("pready low");

endmodule

bind nearest_palette_color_l1 npcl1_checker u_npcl1_checker (.*);
`default_nettype wire
